/* design/median_filter_3x3_core_defines.svh */
// ---------------------------------------------------------------------------
// median_filter_3x3_core_defines
// Assertion helpers for the median filter core.
// The enclosing module provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define MF3_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mf3: same-cycle check failed");

// Next-cycle implication, off during reset
`define MF3_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mf3: next-cycle check failed");

`endif

/* design/mf3_pkg.sv */
// ---------------------------------------------------------------------------
// mf3_pkg
// Types, constants and the median-of-nine network for the 3x3 median core.
// ---------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_BITS      = 8;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = 13;
    localparam int WREG_BITS     = 11;
    localparam int HREG_BITS     = 13;
    localparam int CNT_BITS      = 23;
    localparam int WIN_SIZE      = 9;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 13;
    localparam int NET_STEPS     = 19;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [WREG_BITS-1:0] WIDTH_RESET  = WREG_BITS'(640);
    localparam logic [HREG_BITS-1:0] HEIGHT_RESET = HREG_BITS'(480);
    localparam logic [CNT_BITS-1:0]  TOTAL_RESET  = CNT_BITS'(640 * 480 - 1);

    typedef logic [PIX_BITS-1:0] pixel_t;
    typedef pixel_t [WIN_SIZE-1:0] window_t;

    typedef struct packed {
        pixel_t pixel_in;
        logic   drain;
    } pix_in_t;

    typedef struct packed {
        pixel_t pixel_out;
        logic   frame_last;
    } res_out_t;

    // compare-exchange pairs of the median-of-nine network
    localparam int SWAP_LO [NET_STEPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0,
                                          5, 4, 3, 1, 2, 4, 2, 4, 2};
    localparam int SWAP_HI [NET_STEPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3,
                                          8, 7, 6, 4, 5, 7, 4, 6, 4};

    function automatic pixel_t median9(input window_t win);
        window_t p;
        pixel_t  t;
        p = win;
        for (int k = 0; k < NET_STEPS; k++)
        begin
            if (p[SWAP_LO[k]] > p[SWAP_HI[k]])
            begin
                t              = p[SWAP_LO[k]];
                p[SWAP_LO[k]]  = p[SWAP_HI[k]];
                p[SWAP_HI[k]]  = t;
            end
        end
        return p[4];
    endfunction

endpackage

/* design/median_filter_3x3_core.sv */
// ---------------------------------------------------------------------------
// median_filter_3x3_core
// Streaming 3x3 median filter over raster-order grey pixels, two line stores.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  pix      | in  | pix_valid/pix_ready  | pix_data  (pixel_in, drain)
//  res      | out | res_valid/res_ready  | res_data  (pixel_out, frame_last)
//  cfg      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle unless a held result stalls the window stage. An item
// is registered in the window stage, then in the result register; the line
// store read is registered, so a one-stage window stage sits between input
// and result. Results trail the stream by a row plus one pixel.
// Reset clears counters and window; line stores are left unset.
// A held result stalls the window stage, and with it the input, only when
// the item in that stage produces a result.
`include "median_filter_3x3_core_defines.svh"

module median_filter_3x3_core
    import mf3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pix_valid,
    output logic                     pix_ready,
    input  pix_in_t                  pix_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_out_t                 res_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // configuration
    logic [WREG_BITS-1:0] eff_w_reg, eff_w_next;
    logic [HREG_BITS-1:0] eff_h_reg, eff_h_next;
    logic [CNT_BITS-1:0]  total_m1_reg, total_m1_next;
    logic                 cfg_wr, wr_width, wr_height;
    logic [WREG_BITS-1:0] new_w;
    logic [HREG_BITS-1:0] new_h;
    logic [WREG_BITS+HREG_BITS-1:0] prod;

    // stream counters
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [CNT_BITS-1:0] out_count_reg, out_count_next;

    // acceptance-side decode
    logic                pix_acc;
    logic [COL_BITS-1:0] w_last, c_new;
    logic [ROW_BITS-1:0] r_new;
    logic                emit_new, last_new, inner_new;
    pixel_t              v_new;

    // window stage
    logic                a_valid_reg;
    pixel_t              a_pix_reg;
    logic [COL_BITS-1:0] a_col_reg;
    logic                a_emit_reg, a_last_reg, a_inner_reg;
    logic                a_fwd_reg;
    pixel_t              a_fwd_top_reg, a_fwd_mid_reg;
    pixel_t              upper_rd_reg, lower_rd_reg;
    pixel_t              a_top, a_mid;
    logic                a_adv;
    window_t             window_reg, win_shift;

    // line stores
    pixel_t upper_mem [MAX_WIDTH];
    pixel_t lower_mem [MAX_WIDTH];

    // result register
    logic     res_valid_reg;
    res_out_t res_data_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign wr_width  = cfg_valid && (cfg_index == REG_IMAGE_WIDTH);
    assign wr_height = cfg_valid && (cfg_index == REG_IMAGE_HEIGHT);
    assign cfg_wr    = wr_width || wr_height;

    always_comb
    begin
        new_w = cfg_data[WREG_BITS-1:0];
        if (new_w == '0)
            new_w = WREG_BITS'(1);
        else if (new_w > WREG_BITS'(MAX_WIDTH))
            new_w = WREG_BITS'(MAX_WIDTH);

        new_h = cfg_data[HREG_BITS-1:0];
        if (new_h == '0)
            new_h = HREG_BITS'(1);
        else if (new_h > HREG_BITS'(MAX_HEIGHT))
            new_h = HREG_BITS'(MAX_HEIGHT);

        eff_w_next    = wr_width  ? new_w : eff_w_reg;
        eff_h_next    = wr_height ? new_h : eff_h_reg;
        prod          = (WREG_BITS+HREG_BITS)'(eff_w_next)
                        * (WREG_BITS+HREG_BITS)'(eff_h_next);
        total_m1_next = CNT_BITS'(prod - (WREG_BITS+HREG_BITS)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg    <= WIDTH_RESET;
            eff_h_reg    <= HEIGHT_RESET;
            total_m1_reg <= TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            eff_w_reg    <= eff_w_next;
            eff_h_reg    <= eff_h_next;
            total_m1_reg <= total_m1_next;
        end
    end

    // ---------------- acceptance and counters ----------------
    assign a_adv     = a_valid_reg && (!a_emit_reg || !res_valid_reg || res_ready);
    assign pix_ready = !a_valid_reg || a_adv;
    assign pix_acc   = pix_valid && pix_ready;

    always_comb
    begin
        w_last    = COL_BITS'(eff_w_reg - WREG_BITS'(1));
        c_new     = (in_col_reg > w_last) ? w_last : in_col_reg;
        r_new     = in_row_reg;
        v_new     = pix_data.drain ? '0 : pix_data.pixel_in;
        // position is at least one row plus one pixel into the frame
        emit_new  = (r_new > ROW_BITS'(1)) || ((r_new == ROW_BITS'(1)) && (c_new != '0));
        last_new  = emit_new && (out_count_reg == total_m1_reg);
        // centre is at (r-1, c-1); column 0 centres wrap to the right border
        inner_new = (c_new >= COL_BITS'(2)) && (r_new >= ROW_BITS'(2))
                    && (r_new < eff_h_reg);

        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        if (cfg_wr)
        begin
            in_col_next    = '0;
            in_row_next    = '0;
            out_count_next = '0;
        end
        else if (pix_acc)
        begin
            if (last_new)
            begin
                in_col_next    = '0;
                in_row_next    = '0;
                out_count_next = '0;
            end
            else
            begin
                if (emit_new)
                    out_count_next = out_count_reg + CNT_BITS'(1);
                if (c_new == w_last)
                begin
                    in_col_next = '0;
                    in_row_next = r_new + ROW_BITS'(1);
                end
                else
                begin
                    in_col_next = c_new + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_count_reg <= out_count_next;
        end
    end

    // ---------------- line stores ----------------
    // read at acceptance, written when the item leaves the window stage
    always_ff @(posedge clk)
    begin
        if (a_adv)
            upper_mem[a_col_reg] <= a_mid;
        if (pix_acc)
            upper_rd_reg <= upper_mem[c_new];
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
            lower_mem[a_col_reg] <= a_pix_reg;
        if (pix_acc)
            lower_rd_reg <= lower_mem[c_new];
    end

    // ---------------- window stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pix_acc)
            a_valid_reg <= 1'b1;
        else if (a_adv)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            a_pix_reg     <= v_new;
            a_col_reg     <= c_new;
            a_emit_reg    <= emit_new;
            a_last_reg    <= last_new;
            a_inner_reg   <= inner_new;
            // same column written at this edge: the store read is stale
            a_fwd_reg     <= a_adv && (c_new == a_col_reg);
            a_fwd_top_reg <= a_mid;
            a_fwd_mid_reg <= a_pix_reg;
        end
    end

    assign a_top = a_fwd_reg ? a_fwd_top_reg : upper_rd_reg;
    assign a_mid = a_fwd_reg ? a_fwd_mid_reg : lower_rd_reg;

    always_comb
    begin
        win_shift    = window_reg;
        win_shift[0] = window_reg[1];
        win_shift[1] = window_reg[2];
        win_shift[2] = a_top;
        win_shift[3] = window_reg[4];
        win_shift[4] = window_reg[5];
        win_shift[5] = a_mid;
        win_shift[6] = window_reg[7];
        win_shift[7] = window_reg[8];
        win_shift[8] = a_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (a_adv)
            window_reg <= win_shift;
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (a_adv && a_emit_reg)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && a_emit_reg)
        begin
            res_data_reg.pixel_out  <= a_inner_reg ? median9(win_shift) : win_shift[4];
            res_data_reg.frame_last <= a_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ---------------- checks ----------------
    `MF3_ASSERT_IMP(a_chk_no_overrun, pix_acc, (!a_valid_reg || a_adv))
    `MF3_ASSERT_IMP(a_chk_col_range, 1'b1, (in_col_reg <= w_last))
    `MF3_ASSERT_IMP(a_chk_inner_pos, (a_valid_reg && a_inner_reg),
                    (a_emit_reg && (a_col_reg >= COL_BITS'(2))))
    `MF3_ASSERT_NXT(a_chk_frame_wrap, (pix_acc && last_new),
                    ((in_col_reg == '0) && (in_row_reg == '0) && (out_count_reg == '0)))

endmodule

/* tb/median_filter_3x3_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_filter_3x3_core_test
// Streams raster frames of random shape and content through the 3x3 median
// core, each frame followed by its drain tail, and checks every result
// against a pixel-exact predictor of the line stores, window and border
// rules. Register writes only happen with the core idle. Sender gaps and
// receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module median_filter_3x3_core_test;
    import mf3_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 240;
    localparam int MAX_AREA      = 240;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = '1;

    typedef enum int unsigned {TONE_FULL, TONE_TIES, TONE_BINARY} tone_e;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     pix_valid = 1'b0;
    logic                     pix_ready;
    pix_in_t                  pix_data  = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    res_out_t                 res_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    pix_in_t  raster_q[$];
    res_out_t expected_pixels[$];

    int          items_queued   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_request   = 0;
    int          hold_left      = 0;
    int          fail_count     = 0;
    int unsigned cycle_count    = 0;

    // predictor state
    logic [WREG_BITS-1:0] width_reg;
    logic [HREG_BITS-1:0] height_reg;
    pixel_t               store_top [MAX_WIDTH];
    pixel_t               store_mid [MAX_WIDTH];
    window_t              nbhd;
    int unsigned          at_col;
    int unsigned          at_row;
    int unsigned          results_out;

    median_filter_3x3_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned cur_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned cur_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h < 1)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic pixel_t middle_of_nine(input window_t win);
        window_t s;
        pixel_t  t;
        s = win;
        for (int i = 1; i < WIN_SIZE; i++)
        begin
            for (int j = i; j > 0; j--)
            begin
                if (s[j-1] > s[j])
                begin
                    t      = s[j-1];
                    s[j-1] = s[j];
                    s[j]   = t;
                end
            end
        end
        return s[4];
    endfunction

    // advance the filter by one accepted item, queue the result it causes
    function automatic void filter_step(input pix_in_t item);
        int unsigned w, h, c, r;
        int          cr, cc;
        pixel_t      v, top, mid;
        bit          last;
        res_out_t    res;
        w = cur_width();
        h = cur_height();
        c = at_col;
        r = at_row;
        v = item.drain ? pixel_t'(0) : item.pixel_in;
        if (c >= w)
            c = w - 1;
        top          = store_top[c];
        mid          = store_mid[c];
        store_top[c] = mid;
        store_mid[c] = v;
        for (int k = 0; k < 3; k++)
        begin
            nbhd[k*3]   = nbhd[k*3+1];
            nbhd[k*3+1] = nbhd[k*3+2];
        end
        nbhd[2] = top;
        nbhd[5] = mid;
        nbhd[8] = v;
        if (r * w + c >= w + 1)
        begin
            // window center trails the input by a row and a pixel
            if (c == 0)
            begin
                cr = int'(r) - 2;
                cc = int'(w) - 1;
            end
            else
            begin
                cr = int'(r) - 1;
                cc = int'(c) - 1;
            end
            if (cr >= 1 && cr <= int'(h) - 2 && cc >= 1 && cc <= int'(w) - 2)
                res.pixel_out = middle_of_nine(nbhd);
            else
                res.pixel_out = nbhd[4];
            last           = (results_out >= w * h - 1);
            res.frame_last = last;
            expected_pixels.push_back(res);
            if (last)
            begin
                at_col      = 0;
                at_row      = 0;
                results_out = 0;
                return;
            end
            results_out = (results_out + 1) & ((1 << CNT_BITS) - 1);
        end
        if (c + 1 >= w)
        begin
            at_col = 0;
            at_row = (r + 1) & ((1 << ROW_BITS) - 1);
        end
        else
        begin
            at_col = c + 1;
            at_row = r;
        end
    endfunction

    function automatic void take_register(input logic [CFG_IDX_BITS-1:0]  idx,
                                          input logic [CFG_DATA_BITS-1:0] val);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[WREG_BITS-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val[HREG_BITS-1:0];
        else
            return;
        at_col      = 0;
        at_row      = 0;
        results_out = 0;
    endfunction

    function automatic pixel_t pick_pixel(input tone_e tone);
        case (tone)
            TONE_FULL: return pixel_t'($urandom_range(255));
            TONE_TIES: return pixel_t'($urandom_range(3));
            default:   return pixel_t'($urandom_range(1) * 255);
        endcase
    endfunction

    // sender: feeds queued items, random gaps when the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix_data  <= '0;
        end
        else
        begin
            if (pix_valid && pix_ready)
                filter_step(pix_data);
            if (!pix_valid || pix_ready)
            begin
                if (raster_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pix_valid <= 1'b1;
                    pix_data  <= raster_q.pop_front();
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            res_ready    <= 1'b0;
            hold_left    = hold_request - 1;
            hold_request = 0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_result
        res_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                $display("%0t: expected no item, got pixel_out=%0d frame_last=%0b",
                         $time, res_data.pixel_out, res_data.frame_last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res_data.pixel_out !== want.pixel_out)
                begin
                    fail_count++;
                    $display("%0t: pixel_out expected %0d got %0d",
                             $time, want.pixel_out, res_data.pixel_out);
                end
                if (res_data.frame_last !== want.frame_last)
                begin
                    fail_count++;
                    $display("%0t: frame_last expected %0b got %0b",
                             $time, want.frame_last, res_data.frame_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d items still expected", $time,
                     expected_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(input pixel_t value, input logic is_drain);
        pix_in_t it;
        it.pixel_in = value;
        it.drain    = is_drain;
        raster_q.push_back(it);
        items_queued++;
    endtask

    // wait until every item is taken and every result is back
    task automatic settle(input int extra);
        while (raster_q.size() != 0 || pix_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        take_register(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one frame plus its drain tail; limit cuts it short, pause waits mid-way
    task automatic push_frame(input int unsigned limit, input bit pause);
        int unsigned w, h, total, pause_at, noise;
        tone_e       tone;
        logic        is_drain;
        w     = cur_width();
        h     = cur_height();
        total = w * h + w + 1;
        if (limit != 0 && limit < total)
            total = limit;
        pause_at = $urandom_range(total - 1, 1);
        tone     = tone_e'($urandom_range(2));
        noise    = ($urandom_range(3) == 0) ? 4 : 0;
        for (int unsigned n = 0; n < total; n++)
        begin
            if (pause && n == pause_at)
                settle(0);
            is_drain = (n >= w * h);
            if ($urandom_range(99) < noise)
                is_drain = !is_drain;
            push_item(pick_pixel(tone), is_drain);
        end
    endtask

    task automatic new_shape();
        logic [CFG_DATA_BITS-1:0] wv, hv;
        int unsigned              sel, we, he;
        sel = $urandom_range(19);
        if (sel == 0)
            wv = '0;
        else if (sel < 3)
            wv = CFG_DATA_BITS'(sel);
        else if (sel < 15)
            wv = CFG_DATA_BITS'($urandom_range(10, 3));
        else if (sel < 19)
            wv = CFG_DATA_BITS'($urandom_range(40, 11));
        else
            wv = CFG_DATA_BITS'(13'h1800 | $urandom_range(12, 3));  // upper bits dropped
        sel = $urandom_range(19);
        if (sel == 0)
            hv = '0;
        else if (sel == 1)
            hv = CFG_DATA_BITS'(1);
        else if (sel < 16)
            hv = CFG_DATA_BITS'($urandom_range(8, 2));
        else
            hv = CFG_DATA_BITS'($urandom_range(20, 9));
        we = 32'(wv[WREG_BITS-1:0]);
        if (we == 0)
            we = 1;
        he = (hv == '0) ? 1 : 32'(hv);
        if (we * he > MAX_AREA)
            hv = CFG_DATA_BITS'(MAX_AREA / we);
        if ($urandom_range(4) == 0)
            write_reg(CFG_IDX_BITS'($urandom_range(255, 2)), CFG_DATA_BITS'($urandom));
        if ($urandom_range(1) != 0)
        begin
            write_reg(REG_IMAGE_WIDTH, wv);
            write_reg(REG_IMAGE_HEIGHT, hv);
        end
        else
        begin
            write_reg(REG_IMAGE_HEIGHT, hv);
            write_reg(REG_IMAGE_WIDTH, wv);
        end
    endtask

    initial
    begin
        int          quota;
        int unsigned cut, w, h;
        bit          need_shape;
        bit          first;

        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        nbhd        = '0;
        at_col      = 0;
        at_row      = 0;
        results_out = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            store_top[i] = '0;
            store_mid[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame: one interior median, a drain inside the frame, and a
        // stray pixel inside the drain tail
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
        push_item(8'd0, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'd7, 1'b0);
        push_item(8'd200, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'd9, 1'b0);
        push_item(8'd1, 1'b0);
        push_item(8'd128, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'd55, 1'b0);
        push_item(8'd0, 1'b1);
        push_item(8'hAA, 1'b1);
        settle(SETTLE_CYCLES);

        // zero in both registers acts as one; two 1x1 frames back to back
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h00, 1'b1);
        push_item(8'h80, 1'b0);
        push_item(8'h11, 1'b1);
        push_item(8'hFF, 1'b1);
        settle(SETTLE_CYCLES);

        // a write to an unmapped index must not restart the frame
        push_item(8'h3C, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(REG_UNMAPPED, '1);
        push_item(8'h00, 1'b1);
        push_item(8'h00, 1'b1);
        settle(SETTLE_CYCLES);

        need_shape = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            quota = items_queued + RANDOM_ITEMS / 4;
            if (ph == 0)
            begin
                // receiver holds off while a wide frame streams in
                settle(SETTLE_CYCLES);
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(24));
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(6));
                @(negedge clk);
                hold_request = 300;
                push_frame(0, 1'b0);
                need_shape = 1'b1;
            end
            first = 1'b1;
            while (items_queued < quota)
            begin
                if (need_shape || $urandom_range(2) == 0)
                begin
                    settle(SETTLE_CYCLES);
                    new_shape();
                end
                need_shape = 1'b0;
                cut        = 0;
                if ($urandom_range(7) == 0)
                begin
                    // broken frame: stop part way, then restart by a register write
                    w          = cur_width();
                    h          = cur_height();
                    cut        = $urandom_range(w * h + w, 1);
                    need_shape = 1'b1;
                end
                push_frame(cut, first || $urandom_range(5) == 0);
                first = 1'b0;
            end
        end

        // register extremes: both clamp, line stores used to full depth
        settle(SETTLE_CYCLES);
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, '1);
        push_frame(MAX_WIDTH + 6, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(1));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(MAX_HEIGHT));
        push_frame(40, 1'b0);

        settle(SETTLE_CYCLES * 4);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/mf3_pkg.sv
design/median_filter_3x3_core.sv
tb/median_filter_3x3_core_test.sv
